[rtl/quadratic_root_solver_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the quadratic root solver core
// Checks compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define QRSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define QRSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define QRSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define QRSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/qrs_pkg.sv]
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared constants, class codes and types of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEF_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int CLS_W          = 3;

    localparam logic [CLS_W-1:0] CLS_TWO    = 3'd0;
    localparam logic [CLS_W-1:0] CLS_DOUBLE = 3'd1;
    localparam logic [CLS_W-1:0] CLS_NONE   = 3'd2;
    localparam logic [CLS_W-1:0] CLS_LINEAR = 3'd3;
    localparam logic [CLS_W-1:0] CLS_NOEQ   = 3'd4;
    localparam logic [CLS_W-1:0] CLS_IDENT  = 3'd5;

    typedef struct packed {
        logic [CLS_W-1:0] pre_cls;
        logic             a_neg;
        logic             b_neg;
        logic             c_neg;
    } t_coef_flags;

endpackage

[rtl/quadratic_root_solver_core.sv]
// ----------------------------------------------------------------------------
// quadratic_root_solver_core
// Real roots of a*x^2 + b*x + c = 0 in signed fixed point, class code and
// up to two saturated roots per item.
// ----------------------------------------------------------------------------
//  channel  | valid    | ready    | payload
//  ---------+----------+----------+--------------------------------------------
//  input    | i_valid  | o_ready  | i_coef_a, i_coef_b, i_coef_c
//  result   | o_valid  | i_ready  | o_root_class, o_root_one, o_root_two,
//           |          |          | o_saturated
//
//  One item per cycle sustained unless the result channel stalls; the square
//  root (one root bit per stage) and the two dividers (one quotient bit per
//  stage) are fully pipelined.
//  Synchronous active-low reset clears all valid flags; no clearing pass.
//  A result stall freezes the pipeline; the front queue keeps taking items
//  until its four entries are full.
// ----------------------------------------------------------------------------
`include "quadratic_root_solver_core_macros.svh"

module quadratic_root_solver_core #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [COEF_WIDTH-1:0]      i_coef_a,
    input  logic signed [COEF_WIDTH-1:0]      i_coef_b,
    input  logic signed [COEF_WIDTH-1:0]      i_coef_c,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic        [qrs_pkg::CLS_W-1:0]  o_root_class,
    output logic signed [COEF_WIDTH-1:0]      o_root_one,
    output logic signed [COEF_WIDTH-1:0]      o_root_two,
    output logic                              o_saturated
);

    localparam int W   = COEF_WIDTH;
    localparam int FW  = $bits(qrs_pkg::t_coef_flags);
    localparam int QDW = FW + 3 * W;

    logic                 f_valid, f_ready;
    logic [W-1:0]         f_am, f_bm, f_cm;
    qrs_pkg::t_coef_flags f_flags;

    logic                 q_valid, q_ready;
    logic [QDW-1:0]       q_in, q_out;
    logic [W-1:0]         q_am, q_bm, q_cm;
    qrs_pkg::t_coef_flags q_flags;

    logic                 chk_not_two, chk_empty, chk_quiet;

    qrs_front #(
        .COEF_WIDTH (W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_coef_a (i_coef_a),
        .i_coef_b (i_coef_b),
        .i_coef_c (i_coef_c),
        .o_valid  (f_valid),
        .i_ready  (f_ready),
        .o_am     (f_am),
        .o_bm     (f_bm),
        .o_cm     (f_cm),
        .o_flags  (f_flags)
    );

    assign q_in = {f_flags, f_am, f_bm, f_cm};

    qrs_queue #(
        .DATA_W (QDW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (q_in),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_out)
    );

    assign q_flags = qrs_pkg::t_coef_flags'(q_out[QDW-1 -: FW]);
    assign q_am    = q_out[3*W-1 -: W];
    assign q_bm    = q_out[2*W-1 -: W];
    assign q_cm    = q_out[W-1:0];

    qrs_back #(
        .COEF_WIDTH (W),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .o_ready      (q_ready),
        .i_am         (q_am),
        .i_bm         (q_bm),
        .i_cm         (q_cm),
        .i_flags      (q_flags),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_root_class (o_root_class),
        .o_root_one   (o_root_one),
        .o_root_two   (o_root_two),
        .o_saturated  (o_saturated)
    );

    assign chk_not_two = o_valid && (o_root_class != qrs_pkg::CLS_TWO);
    assign chk_empty   = o_valid && (o_root_class inside
                         {qrs_pkg::CLS_NONE, qrs_pkg::CLS_NOEQ, qrs_pkg::CLS_IDENT});
    assign chk_quiet   = (o_root_one == '0) && !o_saturated;

    `QRSC_ASSERT_IMP(a_root_two_only_two, i_clk, i_rst_n, chk_not_two, o_root_two == '0)
    `QRSC_ASSERT_IMP(a_no_root_classes, i_clk, i_rst_n, chk_empty, chk_quiet)
    `QRSC_ASSERT_NXT(a_front_loads, i_clk, i_rst_n, i_valid && o_ready, f_valid)

endmodule

[rtl/qrs_front.sv]
// ----------------------------------------------------------------------------
// qrs_front
// Input register: coefficient magnitudes, signs and preliminary class.
// ----------------------------------------------------------------------------
module qrs_front #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COEF_WIDTH-1:0]  i_coef_a,
    input  logic signed [COEF_WIDTH-1:0]  i_coef_b,
    input  logic signed [COEF_WIDTH-1:0]  i_coef_c,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic        [COEF_WIDTH-1:0]  o_am,
    output logic        [COEF_WIDTH-1:0]  o_bm,
    output logic        [COEF_WIDTH-1:0]  o_cm,
    output qrs_pkg::t_coef_flags          o_flags
);

    localparam int W = COEF_WIDTH;

    logic                 r_valid;
    logic [W-1:0]         r_am, r_bm, r_cm;
    qrs_pkg::t_coef_flags r_flags;

    logic [W-1:0]         ua, ub, uc;
    logic [W-1:0]         n_am, n_bm, n_cm;
    qrs_pkg::t_coef_flags n_flags;

    assign ua = i_coef_a;
    assign ub = i_coef_b;
    assign uc = i_coef_c;

    always_comb begin
        n_am = ua[W-1] ? (~ua + W'(1)) : ua;
        n_bm = ub[W-1] ? (~ub + W'(1)) : ub;
        n_cm = uc[W-1] ? (~uc + W'(1)) : uc;
        n_flags.a_neg = ua[W-1];
        n_flags.b_neg = ub[W-1];
        n_flags.c_neg = uc[W-1];
        if (ua == '0 && ub == '0) begin
            n_flags.pre_cls = (uc == '0) ? qrs_pkg::CLS_IDENT : qrs_pkg::CLS_NOEQ;
        end else if (ua == '0) begin
            n_flags.pre_cls = qrs_pkg::CLS_LINEAR;
        end else begin
            n_flags.pre_cls = qrs_pkg::CLS_TWO;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_am    <= n_am;
            r_bm    <= n_bm;
            r_cm    <= n_cm;
            r_flags <= n_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_am    = r_am;
    assign o_bm    = r_bm;
    assign o_cm    = r_cm;
    assign o_flags = r_flags;

endmodule

[rtl/qrs_queue.sv]
// ----------------------------------------------------------------------------
// qrs_queue
// Small FIFO between the front register and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module qrs_queue #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_data
);

    localparam int DEPTH = qrs_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [0:DEPTH-1];
    logic [PW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]     r_count;
    logic              push, pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[rtl/qrs_sqrt.sv]
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined integer square root, one root bit per stage, with side band.
// ----------------------------------------------------------------------------
module qrs_sqrt #(
    parameter int IN_W = 66,
    parameter int SB_W = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [IN_W-1:0]     i_rad,
    input  logic [SB_W-1:0]     i_sb,
    output logic                o_valid,
    output logic [IN_W/2-1:0]   o_root,
    output logic [SB_W-1:0]     o_sb
);

    localparam int NS = IN_W / 2;
    localparam int RW = NS + 3;

    logic [RW-1:0]   r_rem  [0:NS-1];
    logic [NS-1:0]   r_root [0:NS-1];
    logic [IN_W-1:0] r_rad  [0:NS-1];
    logic [SB_W-1:0] r_sb   [0:NS-1];
    logic            r_v    [0:NS-1];

    for (genvar k = 0; k < NS; k++) begin : g_st
        logic [RW-1:0]   rem_i, t_rem, trial, n_rem;
        logic [NS-1:0]   root_i, n_root;
        logic [IN_W-1:0] rad_i;
        logic [SB_W-1:0] sb_i;
        logic            v_i, ge;

        if (k == 0) begin : g_in
            assign rem_i  = '0;
            assign root_i = '0;
            assign rad_i  = i_rad;
            assign sb_i   = i_sb;
            assign v_i    = i_valid;
        end else begin : g_chain
            assign rem_i  = r_rem[k-1];
            assign root_i = r_root[k-1];
            assign rad_i  = r_rad[k-1];
            assign sb_i   = r_sb[k-1];
            assign v_i    = r_v[k-1];
        end

        always_comb begin
            t_rem  = {rem_i[RW-3:0], rad_i[IN_W-1:IN_W-2]};
            trial  = RW'({root_i, 2'b01});
            ge     = (t_rem >= trial);
            n_rem  = ge ? (t_rem - trial) : t_rem;
            n_root = {root_i[NS-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_i;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_rad[k]  <= {rad_i[IN_W-3:0], 2'b00};
                r_sb[k]   <= sb_i;
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_root  = r_root[NS-1];
    assign o_sb    = r_sb[NS-1];

endmodule

[rtl/qrs_div.sv]
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 33,
    parameter int SB_W  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SB_W-1:0]   i_sb,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quot,
    output logic [SB_W-1:0]   o_sb
);

    logic [DEN_W-1:0] r_rem [0:NUM_W-1];
    logic [NUM_W-1:0] r_q   [0:NUM_W-1];
    logic [NUM_W-1:0] r_num [0:NUM_W-1];
    logic [DEN_W-1:0] r_den [0:NUM_W-1];
    logic [SB_W-1:0]  r_sb  [0:NUM_W-1];
    logic             r_v   [0:NUM_W-1];

    for (genvar k = 0; k < NUM_W; k++) begin : g_st
        logic [DEN_W-1:0] rem_i, den_i, n_rem;
        logic [NUM_W-1:0] q_i, num_i;
        logic [SB_W-1:0]  sb_i;
        logic [DEN_W:0]   t_rem, dx, diff;
        logic             v_i, ge;

        if (k == 0) begin : g_in
            assign rem_i = '0;
            assign q_i   = '0;
            assign num_i = i_num;
            assign den_i = i_den;
            assign sb_i  = i_sb;
            assign v_i   = i_valid;
        end else begin : g_chain
            assign rem_i = r_rem[k-1];
            assign q_i   = r_q[k-1];
            assign num_i = r_num[k-1];
            assign den_i = r_den[k-1];
            assign sb_i  = r_sb[k-1];
            assign v_i   = r_v[k-1];
        end

        always_comb begin
            t_rem = {rem_i, num_i[NUM_W-1]};
            dx    = {1'b0, den_i};
            ge    = (t_rem >= dx);
            diff  = t_rem - dx;
            n_rem = ge ? diff[DEN_W-1:0] : t_rem[DEN_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_i;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_q[k]   <= {q_i[NUM_W-2:0], ge};
                r_num[k] <= {num_i[NUM_W-2:0], 1'b0};
                r_den[k] <= den_i;
                r_sb[k]  <= sb_i;
            end
        end
    end

    assign o_valid = r_v[NUM_W-1];
    assign o_quot  = r_q[NUM_W-1];
    assign o_sb    = r_sb[NUM_W-1];

endmodule

[rtl/qrs_back.sv]
// ----------------------------------------------------------------------------
// qrs_back
// Arithmetic pipeline: products, discriminant, square root, root division,
// saturation and the output register.
// ----------------------------------------------------------------------------
module qrs_back #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic        [COEF_WIDTH-1:0]       i_am,
    input  logic        [COEF_WIDTH-1:0]       i_bm,
    input  logic        [COEF_WIDTH-1:0]       i_cm,
    input  qrs_pkg::t_coef_flags               i_flags,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic        [qrs_pkg::CLS_W-1:0]   o_root_class,
    output logic signed [COEF_WIDTH-1:0]       o_root_one,
    output logic signed [COEF_WIDTH-1:0]       o_root_two,
    output logic                               o_saturated
);

    localparam int W     = COEF_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int H     = (W + 1) / 2;
    localparam int HW    = W - H;
    localparam int W2    = 2 * W;
    localparam int DW    = 2 * W + 2;
    localparam int NS    = W + 1;
    localparam int NUM_W = W + 1 + F;
    localparam int FW    = $bits(qrs_pkg::t_coef_flags);
    localparam int CTX_W = FW + 3 * W;
    localparam int CLW   = qrs_pkg::CLS_W;

    logic en;

    // product stage
    logic [2*H-1:0]  r_bb_ll, r_ac_ll;
    logic [W-1:0]    r_bb_lh, r_ac_lh, r_ac_hl;
    logic [2*HW-1:0] r_bb_hh, r_ac_hh;
    logic [CTX_W-1:0] r_m1_ctx;
    logic            r_m1_v;

    // product sum stage
    logic [W2-1:0]    r_b2, r_ac, n_b2, n_ac;
    logic [CTX_W-1:0] r_m2_ctx;
    logic             r_m2_v;

    // discriminant stage
    qrs_pkg::t_coef_flags m2_fl, n_d_fl;
    logic [W-1:0]     m2_cm;
    logic [DW-1:0]    b2x, ac4, n_d;
    logic             disagree;
    logic [DW-1:0]    r_d;
    logic [CTX_W-1:0] r_d_ctx;
    logic             r_d_v;

    // square root
    logic             sq_v;
    logic [NS-1:0]    sq_s;
    logic [CTX_W-1:0] sq_ctx;

    // root forming stage
    qrs_pkg::t_coef_flags sq_fl;
    logic [W-1:0]     sq_am, sq_bm, sq_cm;
    logic [W:0]       bmx, m1, m2;
    logic             n1, n2;
    logic [W:0]       n_num1, n_den;
    logic             n_neg1, n_neg2;
    logic [CLW-1:0]   n_cls;
    logic [W:0]       r_f_num1, r_f_num2, r_f_den;
    logic             r_f_neg1, r_f_neg2;
    logic [CLW-1:0]   r_f_cls;
    logic             r_f_v;

    // dividers
    logic             dv1_v, dv2_v;
    logic [NUM_W-1:0] dv1_q, dv2_q;
    logic [CLW:0]     dv1_sb;
    logic             dv2_sb;

    // output
    logic [CLW-1:0]   out_cls;
    logic [W:0]       fix1, fix2;
    logic [W-1:0]     n_r1, n_r2;
    logic             n_sat;
    logic             r_out_v;
    logic [CLW-1:0]   r_out_cls;
    logic [W-1:0]     r_out_r1, r_out_r2;
    logic             r_out_sat;

    function automatic logic [W:0] fix_root(input logic [NUM_W-1:0] q, input logic neg);
        logic big, exact, over;
        logic [W-1:0] val;
        big   = |q[NUM_W-1:W-1];
        exact = (q[NUM_W-1:W-1] == (NUM_W-W+1)'(1)) && (q[W-2:0] == '0);
        over  = neg ? (big && !exact) : big;
        if (over) begin
            val = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            val = neg ? (~q[W-1:0] + W'(1)) : q[W-1:0];
        end
        return {over, val};
    endfunction

    assign en      = !r_out_v || i_ready;
    assign o_ready = en;

    // ---------------- product stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
            r_d_v  <= 1'b0;
            r_f_v  <= 1'b0;
        end else if (en) begin
            r_m1_v <= i_valid;
            r_m2_v <= r_m1_v;
            r_d_v  <= r_m2_v;
            r_f_v  <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bb_ll  <= i_bm[H-1:0] * i_bm[H-1:0];
            r_bb_lh  <= i_bm[H-1:0] * i_bm[W-1:H];
            r_bb_hh  <= i_bm[W-1:H] * i_bm[W-1:H];
            r_ac_ll  <= i_am[H-1:0] * i_cm[H-1:0];
            r_ac_lh  <= i_am[H-1:0] * i_cm[W-1:H];
            r_ac_hl  <= i_am[W-1:H] * i_cm[H-1:0];
            r_ac_hh  <= i_am[W-1:H] * i_cm[W-1:H];
            r_m1_ctx <= {i_flags, i_am, i_bm, i_cm};
        end
    end

    // ---------------- product sum stage ----------------
    always_comb begin
        n_b2 = W2'(r_bb_ll) + (W2'(r_bb_lh) << (H + 1)) + (W2'(r_bb_hh) << (2 * H));
        n_ac = W2'(r_ac_ll) + (W2'(r_ac_lh) << H) + (W2'(r_ac_hl) << H)
             + (W2'(r_ac_hh) << (2 * H));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b2     <= n_b2;
            r_ac     <= n_ac;
            r_m2_ctx <= r_m1_ctx;
        end
    end

    // ---------------- discriminant stage ----------------
    always_comb begin
        m2_fl    = qrs_pkg::t_coef_flags'(r_m2_ctx[CTX_W-1 -: FW]);
        m2_cm    = r_m2_ctx[W-1:0];
        b2x      = DW'(r_b2);
        ac4      = {r_ac, 2'b00};
        disagree = (m2_fl.a_neg != m2_fl.c_neg) && (m2_cm != '0);
        n_d      = disagree ? (b2x + ac4) : (b2x - ac4);
        n_d_fl   = m2_fl;
        if (m2_fl.pre_cls == qrs_pkg::CLS_TWO && !disagree && (b2x < ac4)) begin
            n_d_fl.pre_cls = qrs_pkg::CLS_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d     <= n_d;
            r_d_ctx <= {n_d_fl, r_m2_ctx[3*W-1:0]};
        end
    end

    qrs_sqrt #(
        .IN_W (DW),
        .SB_W (CTX_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_d_v),
        .i_rad   (r_d),
        .i_sb    (r_d_ctx),
        .o_valid (sq_v),
        .o_root  (sq_s),
        .o_sb    (sq_ctx)
    );

    // ---------------- root forming stage ----------------
    always_comb begin
        sq_fl = qrs_pkg::t_coef_flags'(sq_ctx[CTX_W-1 -: FW]);
        sq_am = sq_ctx[3*W-1 -: W];
        sq_bm = sq_ctx[2*W-1 -: W];
        sq_cm = sq_ctx[W-1:0];
        bmx   = {1'b0, sq_bm};

        if (sq_fl.b_neg) begin
            m1 = bmx + sq_s;
            n1 = 1'b0;
        end else if (sq_s >= bmx) begin
            m1 = sq_s - bmx;
            n1 = 1'b0;
        end else begin
            m1 = bmx - sq_s;
            n1 = 1'b1;
        end

        if (!sq_fl.b_neg) begin
            m2 = bmx + sq_s;
            n2 = 1'b1;
        end else if (bmx >= sq_s) begin
            m2 = bmx - sq_s;
            n2 = 1'b0;
        end else begin
            m2 = sq_s - bmx;
            n2 = 1'b1;
        end

        n_cls = sq_fl.pre_cls;
        if (sq_fl.pre_cls == qrs_pkg::CLS_TWO && sq_s == '0) begin
            n_cls = qrs_pkg::CLS_DOUBLE;
        end

        if (sq_fl.pre_cls == qrs_pkg::CLS_LINEAR) begin
            n_num1 = {1'b0, sq_cm};
            n_den  = {1'b0, sq_bm};
            n_neg1 = ((!sq_fl.c_neg) != sq_fl.b_neg) && (sq_cm != '0);
        end else begin
            n_num1 = m1;
            n_den  = {sq_am, 1'b0};
            n_neg1 = (n1 != sq_fl.a_neg) && (m1 != '0);
        end
        n_neg2 = (n2 != sq_fl.a_neg) && (m2 != '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_num1 <= n_num1;
            r_f_num2 <= m2;
            r_f_den  <= n_den;
            r_f_neg1 <= n_neg1;
            r_f_neg2 <= n_neg2;
            r_f_cls  <= n_cls;
        end
    end

    qrs_div #(
        .NUM_W (NUM_W),
        .DEN_W (W + 1),
        .SB_W  (CLW + 1)
    ) u_div_one (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_f_v),
        .i_num   ({r_f_num1, F'(0)}),
        .i_den   (r_f_den),
        .i_sb    ({r_f_cls, r_f_neg1}),
        .o_valid (dv1_v),
        .o_quot  (dv1_q),
        .o_sb    (dv1_sb)
    );

    qrs_div #(
        .NUM_W (NUM_W),
        .DEN_W (W + 1),
        .SB_W  (1)
    ) u_div_two (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_f_v),
        .i_num   ({r_f_num2, F'(0)}),
        .i_den   (r_f_den),
        .i_sb    (r_f_neg2),
        .o_valid (dv2_v),
        .o_quot  (dv2_q),
        .o_sb    (dv2_sb)
    );

    // ---------------- saturation and output register ----------------
    always_comb begin
        out_cls = dv1_sb[CLW:1];
        fix1    = fix_root(dv1_q, dv1_sb[0]);
        fix2    = fix_root(dv2_q, dv2_sb);
        n_r1    = '0;
        n_r2    = '0;
        n_sat   = 1'b0;
        case (out_cls) inside
            qrs_pkg::CLS_TWO: begin
                n_r1  = fix1[W-1:0];
                n_r2  = fix2[W-1:0];
                n_sat = fix1[W] || fix2[W];
            end
            qrs_pkg::CLS_DOUBLE, qrs_pkg::CLS_LINEAR: begin
                n_r1  = fix1[W-1:0];
                n_sat = fix1[W];
            end
            default: begin
                n_r1  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= dv1_v && dv2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_cls <= out_cls;
            r_out_r1  <= n_r1;
            r_out_r2  <= n_r2;
            r_out_sat <= n_sat;
        end
    end

    assign o_valid      = r_out_v;
    assign o_root_class = r_out_cls;
    assign o_root_one   = r_out_r1;
    assign o_root_two   = r_out_r2;
    assign o_saturated  = r_out_sat;

endmodule

[sim/quadratic_root_solver_core_tb.sv]
// ----------------------------------------------------------------------------
// quadratic_root_solver_core_tb
// Streams coefficient sets through the solver with random idling on both
// channels, predicts class, roots and saturation for each accepted item, and
// compares every result in order against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module quadratic_root_solver_core_tb;

    localparam int CW = qrs_pkg::COEF_WIDTH_DEF;
    localparam int FB = qrs_pkg::FRAC_BITS_DEF;
    localparam int CLW = qrs_pkg::CLS_W;
    localparam int N_RANDOM = 1500;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [CLW-1:0]   cls;
        logic [CW-1:0]    r1;
        logic [CW-1:0]    r2;
        logic             sat;
    } t_roots;

    class root_scoreboard;
        t_roots pending_roots[$];
        int     errors;
        bit     sat_flag;

        function new();
            errors = 0;
        endfunction

        function logic [63:0] magnitude(logic [CW-1:0] raw, output bit neg);
            neg = raw[CW-1];
            return neg ? {32'd0, 32'(0 - raw)} : {32'd0, raw};
        endfunction

        function logic [CW-1:0] divide_root(bit nneg, logic [63:0] nmag,
                                            bit dneg, logic [63:0] dmag);
            logic [127:0] q;
            logic [127:0] lim;
            bit           neg;
            if (dmag == 0) return '0;
            q   = ({64'd0, nmag} << FB) / {64'd0, dmag};
            neg = (nneg != dneg) && (nmag != 0);
            lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
            if (q > lim) begin
                q = lim;
                sat_flag = 1;
            end
            return neg ? CW'(0 - q[CW-1:0]) : q[CW-1:0];
        endfunction

        function logic [63:0] isqrt(logic [127:0] d);
            logic [63:0] r;
            logic [63:0] t;
            r = 0;
            for (int i = 63; i >= 0; i--) begin
                t = r | (64'd1 << i);
                if ({64'd0, t} * {64'd0, t} <= d) r = t;
            end
            return r;
        endfunction

        function t_roots predict_roots(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c);
            t_roots       p;
            bit           an, bn, cn, n1, n2;
            logic [63:0]  am, bm, cm, s, m1, m2;
            logic [127:0] b2, ac4, d;
            am = magnitude(a, an);
            bm = magnitude(b, bn);
            cm = magnitude(c, cn);
            p = '0;
            sat_flag = 0;
            if (am == 0 && bm == 0) begin
                p.cls = (cm == 0) ? qrs_pkg::CLS_IDENT : qrs_pkg::CLS_NOEQ;
            end else if (am == 0) begin
                p.cls = qrs_pkg::CLS_LINEAR;
                p.r1  = divide_root(!cn, cm, bn, bm);
            end else begin
                b2  = {64'd0, bm} * {64'd0, bm};
                ac4 = ({64'd0, am} * {64'd0, cm}) << 2;
                if (an != cn && cm != 0) begin
                    d = b2 + ac4;
                end else if (b2 >= ac4) begin
                    d = b2 - ac4;
                end else begin
                    d = 0;
                    p.cls = qrs_pkg::CLS_NONE;
                end
                if (p.cls == qrs_pkg::CLS_NONE) begin
                end else if (d == 0) begin
                    p.cls = qrs_pkg::CLS_DOUBLE;
                    p.r1  = divide_root(!bn, bm, an, am << 1);
                end else begin
                    s = isqrt(d);
                    p.cls = qrs_pkg::CLS_TWO;
                    if (bn) begin
                        m1 = bm + s; n1 = 0;
                    end else if (s >= bm) begin
                        m1 = s - bm; n1 = 0;
                    end else begin
                        m1 = bm - s; n1 = 1;
                    end
                    if (!bn) begin
                        m2 = bm + s; n2 = 1;
                    end else if (bm >= s) begin
                        m2 = bm - s; n2 = 0;
                    end else begin
                        m2 = s - bm; n2 = 1;
                    end
                    p.r1 = divide_root(n1, m1, an, am << 1);
                    p.r2 = divide_root(n2, m2, an, am << 1);
                end
            end
            p.sat = sat_flag;
            return p;
        endfunction

        function void note_input(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c);
            pending_roots.push_back(predict_roots(a, b, c));
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
            errors++;
        endtask

        task check_result(t_roots got);
            t_roots want;
            if (pending_roots.size() == 0) begin
                report_mismatch("unexpected item", 64'(got.cls), 64'd0);
                return;
            end
            want = pending_roots.pop_front();
            if (got.cls != want.cls)
                report_mismatch("root_class", 64'(got.cls), 64'(want.cls));
            if (got.r1 != want.r1)
                report_mismatch("root_one", 64'(got.r1), 64'(want.r1));
            if (got.r2 != want.r2)
                report_mismatch("root_two", 64'(got.r2), 64'(want.r2));
            if (got.sat != want.sat)
                report_mismatch("saturated", 64'(got.sat), 64'(want.sat));
        endtask
    endclass

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_valid = 0;
    logic                 o_ready;
    logic signed [CW-1:0] i_coef_a = '0;
    logic signed [CW-1:0] i_coef_b = '0;
    logic signed [CW-1:0] i_coef_c = '0;
    logic                 o_valid;
    logic                 i_ready = 0;
    logic [CLW-1:0]       o_root_class;
    logic signed [CW-1:0] o_root_one;
    logic signed [CW-1:0] o_root_two;
    logic                 o_saturated;

    root_scoreboard sb = new();
    bit quiet_phase = 0;
    bit hold_request = 0;
    int idle_count = 0;

    quadratic_root_solver_core dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) sb.note_input(i_coef_a, i_coef_b, i_coef_c);
        if (i_rst_n && o_valid && i_ready)
            sb.check_result({o_root_class, o_root_one, o_root_two, o_saturated});
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_count <= 0;
        else idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                i_ready <= 0;
                repeat (300) @(posedge i_clk);
                hold_request = 0;
            end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                i_ready <= 0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                i_ready <= 1;
                @(posedge i_clk);
            end
        end
    end

    task send_coefs(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c);
        i_valid  <= 1;
        i_coef_a <= a;
        i_coef_b <= b;
        i_coef_c <= c;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    task wait_drained();
        i_valid <= 0;
        @(posedge i_clk);
        while (sb.pending_roots.size() != 0) @(posedge i_clk);
    endtask

    task send_random();
        logic [CW-1:0] a, b, c, x;
        int kind;
        kind = $urandom_range(0, 9);
        a = $urandom;
        b = $urandom;
        c = $urandom;
        case (kind)
            0: a = '0;
            1: begin
                a = '0;
                b = $urandom_range(0, 1) ? '0 : b;
                c = $urandom_range(0, 1) ? '0 : c;
            end
            2: begin
                x = $signed($urandom) >>> $urandom_range(8, 20);
                a = x; c = x; b = $urandom_range(0, 1) ? x << 1 : -(x << 1);
            end
            3, 4: begin
                a = $signed(a) >>> $urandom_range(0, 24);
                b = $signed(b) >>> $urandom_range(0, 24);
                c = $signed(c) >>> $urandom_range(0, 24);
            end
            5: a = $signed(a) >>> $urandom_range(16, 31);
            default: ;
        endcase
        send_coefs(a, b, c);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_coefs(0, 0, 0);
        send_coefs(0, 0, 32'h0001_0000);
        send_coefs(0, 32'h0002_0000, 32'h0001_0000);
        send_coefs(0, 32'h0000_0001, 32'h7fff_ffff);
        send_coefs(0, 32'h0000_0001, 32'h8000_0000);
        send_coefs(0, 32'hffff_ffff, 32'h8000_0000);
        send_coefs(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
        send_coefs(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
        send_coefs(32'h0001_0000, 32'h0000_0000, 32'hffff_0000);
        send_coefs(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000);
        send_coefs(32'hffff_0000, 32'h0001_0000, 32'h0006_0000);
        send_coefs(32'h0000_0001, 32'h7fff_ffff, 32'h0000_0000);
        send_coefs(32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff);
        send_coefs(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        send_coefs(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        send_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_coefs(32'h7fff_ffff, 32'h0000_0000, 32'h7fff_ffff);
        send_coefs(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_coefs(32'h0000_0001, 32'h0000_0002, 32'h0000_0001);

        wait_drained();
        hold_request = 1;
        for (int i = 0; i < 40; i++) send_random();
        for (int i = 0; i < N_RANDOM - 40; i++) begin
            if (i == 600) wait_drained();
            if (i == N_RANDOM - 200) quiet_phase = 1;
            send_random();
        end
        i_valid <= 0;
        @(posedge i_clk);
        while (sb.pending_roots.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_roots.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
